[src/mexp_pkg.sv]
// Shared widths, constants and types for the modular exponentiation block.
package mexp_pkg;

    localparam int MOD_WIDTH  = 32;
    localparam int EXP_WIDTH  = 63;
    localparam int BASE_WIDTH = 63;
    localparam int OUT_WIDTH  = 32;
    localparam int CNT_WIDTH  = $clog2(BASE_WIDTH);

    // Per-cycle control of one serial modular multiplier.
    typedef struct packed {
        logic clear;
        logic step;
        logic ybit;
    } t_mul_ctl;

endpackage

[src/mexp_mulmod.sv]
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle while step is set, MSB first.
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic                 i_clk,
    input  t_mul_ctl             i_ctl,
    input  logic [MOD_WIDTH-1:0] i_x,
    input  logic [MOD_WIDTH-1:0] i_mod,
    output logic [MOD_WIDTH-1:0] o_prod
);

    logic [MOD_WIDTH-1:0] r_p;
    logic [MOD_WIDTH-1:0] n_p;
    logic [MOD_WIDTH:0]   dbl;
    logic [MOD_WIDTH:0]   sum;
    logic [MOD_WIDTH:0]   mod_ext;

    assign mod_ext = {1'b0, i_mod};

    always_comb begin
        // p = 2p mod m, then p = p + x mod m when the multiplier bit is set
        dbl = {r_p, 1'b0};
        if (dbl >= mod_ext) begin
            dbl = dbl - mod_ext;
        end
        sum = {1'b0, dbl[MOD_WIDTH-1:0]};
        if (i_ctl.ybit) begin
            sum = sum + {1'b0, i_x};
        end
        if (sum >= mod_ext) begin
            sum = sum - mod_ext;
        end
        if (i_ctl.clear) begin
            n_p = '0;
        end else if (i_ctl.step) begin
            n_p = sum[MOD_WIDTH-1:0];
        end else begin
            n_p = r_p;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_prod = r_p;

endmodule

[src/modular_exponentiation.sv]
// Modular exponentiation by right-to-left square-and-multiply over bit-serial multipliers.
//
// Pulse i_start while o_busy is low to hand in base, exponent and modulus; the
// result appears on o_power_mod for exactly one cycle with o_done high, and must
// be taken then, since the block cannot be stalled. A zero exponent returns 1 in the
// cycle after the start. Otherwise the block first reduces the base modulo the
// modulus, one base bit per cycle, passes the setup state, and then, for each
// exponent bit up to the highest set bit, steps through the multiplier bits and
// ends with one update. The serial modular multipliers run the square and the
// multiply side by side. o_busy drops in the strobe cycle.
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [BASE_WIDTH-1:0] i_base_value,
    input  logic [62:0]           i_exponent,
    input  logic [31:0]           i_modulus,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [OUT_WIDTH-1:0]  o_power_mod
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;

    logic [2:0]            r_state,  n_state;
    logic [CNT_WIDTH-1:0]  r_cnt,    n_cnt;
    logic [BASE_WIDTH-1:0] r_base,   n_base;
    logic [EXP_WIDTH-1:0]  r_exp,    n_exp;
    logic [MOD_WIDTH-1:0]  r_mod,    n_mod;
    logic [MOD_WIDTH-1:0]  r_acc,    n_acc;
    logic [MOD_WIDTH-1:0]  r_pw,     n_pw;
    logic [MOD_WIDTH-1:0]  r_y,      n_y;
    logic                  r_done,   n_done;
    logic [OUT_WIDTH-1:0]  r_out,    n_out;

    t_mul_ctl              mul_ctl;
    t_mul_ctl              sq_ctl;
    logic [MOD_WIDTH-1:0]  sq_x;
    logic [MOD_WIDTH-1:0]  mul_prod;
    logic [MOD_WIDTH-1:0]  sq_prod;
    logic [EXP_WIDTH-1:0]  exp_shr;
    logic [MOD_WIDTH-1:0]  acc_upd;
    logic                  accept;

    assign accept  = i_start && (r_state == ST_IDLE);
    assign exp_shr = r_exp >> 1;
    assign acc_upd = r_exp[0] ? mul_prod : r_acc;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_base  = r_base;
        n_exp   = r_exp;
        n_mod   = r_mod;
        n_acc   = r_acc;
        n_pw    = r_pw;
        n_y     = r_y;
        n_done  = 1'b0;
        n_out   = r_out;
        mul_ctl = '0;
        sq_ctl  = '0;
        sq_x    = r_pw;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_base = i_base_value;
                    n_exp  = i_exponent[EXP_WIDTH-1:0];
                    n_mod  = i_modulus[MOD_WIDTH-1:0];
                    n_acc  = MOD_WIDTH'(1);
                    n_cnt  = '0;
                    sq_ctl.clear = 1'b1;
                    if (i_exponent[EXP_WIDTH-1:0] == '0) begin
                        n_done = 1'b1;
                        n_out  = OUT_WIDTH'(1);
                    end else begin
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                // base mod m: the squaring unit with x = 1 and the base bits as multiplier
                sq_x        = MOD_WIDTH'(1);
                sq_ctl.step = 1'b1;
                sq_ctl.ybit = r_base[BASE_WIDTH-1];
                n_base      = r_base << 1;
                n_cnt       = r_cnt + CNT_WIDTH'(1);
                if (r_cnt == CNT_WIDTH'(BASE_WIDTH - 1)) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_pw          = sq_prod;
                n_y           = sq_prod;
                n_cnt         = '0;
                mul_ctl.clear = 1'b1;
                sq_ctl.clear  = 1'b1;
                n_state       = ST_MUL;
            end
            ST_MUL: begin
                mul_ctl.step = 1'b1;
                mul_ctl.ybit = r_y[MOD_WIDTH-1];
                sq_ctl.step  = 1'b1;
                sq_ctl.ybit  = r_y[MOD_WIDTH-1];
                n_y          = r_y << 1;
                n_cnt        = r_cnt + CNT_WIDTH'(1);
                if (r_cnt == CNT_WIDTH'(MOD_WIDTH - 1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_acc         = acc_upd;
                n_pw          = sq_prod;
                n_y           = sq_prod;
                n_exp         = exp_shr;
                n_cnt         = '0;
                mul_ctl.clear = 1'b1;
                sq_ctl.clear  = 1'b1;
                // stop once no set exponent bit remains
                if (exp_shr == '0) begin
                    n_done  = 1'b1;
                    n_out   = (r_mod == '0) ? '0 : OUT_WIDTH'(acc_upd);
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_exp  <= n_exp;
        r_mod  <= n_mod;
        r_acc  <= n_acc;
        r_pw   <= n_pw;
        r_y    <= n_y;
        r_out  <= n_out;
    end

    mexp_mulmod u_mul (
        .i_clk  (i_clk),
        .i_ctl  (mul_ctl),
        .i_x    (r_acc),
        .i_mod  (r_mod),
        .o_prod (mul_prod)
    );

    mexp_mulmod u_sq (
        .i_clk  (i_clk),
        .i_ctl  (sq_ctl),
        .i_x    (sq_x),
        .i_mod  (r_mod),
        .o_prod (sq_prod)
    );

    assign o_busy      = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_power_mod = r_out;

endmodule

[verif/tb_modular_exponentiation.sv]
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 100ps

module tb_modular_exponentiation;
    import mexp_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TAIL_CYCLES  = 2200;
    localparam int NUM_DIRECTED = 20;
    localparam int NUM_PHASES   = 3;
    localparam int PHASE_ITEMS  = 87;
    localparam int WANT_DEPTH   = 512;

    localparam logic [BASE_WIDTH-1:0] MAX_BASE = {BASE_WIDTH{1'b1}};
    localparam logic [EXP_WIDTH-1:0]  MAX_EXP  = {EXP_WIDTH{1'b1}};
    localparam logic [MOD_WIDTH-1:0]  MAX_MOD  = {MOD_WIDTH{1'b1}};

    // Sender idle percentage per random phase.
    localparam int SEND_IDLE_PCT [NUM_PHASES] = '{14, 48, 0};

    typedef struct {
        logic [BASE_WIDTH-1:0] base;
        logic [EXP_WIDTH-1:0]  expo;
        logic [MOD_WIDTH-1:0]  modulus;
        bit                    fixed;
        logic [OUT_WIDTH-1:0]  fixed_val;
    } t_mexp_case;

    // Rows with fixed set carry their result; the others go through the predictor.
    t_mexp_case directed_vec [NUM_DIRECTED] = '{
        '{63'd0,      63'd0,    32'd0,   1'b1, 32'd1},
        '{63'd5,      63'd0,    32'd1,   1'b1, 32'd1},
        '{MAX_BASE,   63'd0,    MAX_MOD, 1'b1, 32'd1},
        '{63'd0,      63'd1,    32'd0,   1'b1, 32'd0},
        '{MAX_BASE,   MAX_EXP,  32'd0,   1'b1, 32'd0},
        '{63'd12345,  63'd7,    32'd1,   1'b1, 32'd0},
        '{63'd0,      63'd5,    32'd97,  1'b1, 32'd0},
        '{63'd1,      MAX_EXP,  MAX_MOD, 1'b1, 32'd1},
        '{63'd7,      63'd1,    32'd13,  1'b1, 32'd7},
        '{63'hFFFF_FFFF, 63'd3, MAX_MOD, 1'b1, 32'd0},
        '{MAX_BASE,   MAX_EXP,  MAX_MOD, 1'b0, 32'd0},
        '{MAX_BASE,   63'd1,    MAX_MOD, 1'b0, 32'd0},
        '{63'd2, 63'h4000_0000_0000_0000, 32'd1000000007, 1'b0, 32'd0},
        '{63'd3,      63'd62,   32'hFFFF_FFFB, 1'b0, 32'd0},
        '{63'd2,      63'd10,   32'd1000, 1'b0, 32'd0},
        '{MAX_BASE,   63'd2,    32'hFFFF_FFFE, 1'b0, 32'd0},
        '{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 32'd0},
        '{63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 32'h5555_5555, 1'b0, 32'd0},
        '{63'd123456789, 63'd65537, 32'h8000_0000, 1'b0, 32'd0},
        '{MAX_BASE,   MAX_EXP,  32'h8000_0001, 1'b0, 32'd0}
    };

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_start      = 1'b0;
    logic [BASE_WIDTH-1:0] i_base_value = '0;
    logic [62:0]           i_exponent   = '0;
    logic [31:0]           i_modulus    = '0;
    logic                  o_busy;
    logic                  o_done;
    logic [OUT_WIDTH-1:0]  o_power_mod;

    // Expected results in order: written by the sender, read by the checker.
    logic [OUT_WIDTH-1:0]  want_fifo [WANT_DEPTH];
    int                    want_wr        = 0;
    int                    want_rd        = 0;
    logic [OUT_WIDTH-1:0]  want_power_mod;
    int                    mismatch_count = 0;
    int                    cycle_count    = 0;

    modular_exponentiation u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_base_value (i_base_value),
        .i_exponent   (i_exponent),
        .i_modulus    (i_modulus),
        .o_busy       (o_busy),
        .o_done       (o_done),
        .o_power_mod  (o_power_mod)
    );

    always #1 i_clk = ~i_clk;

    // Right-to-left square-and-multiply; residues stay below 2^32 so products fit in 64 bits.
    function automatic logic [OUT_WIDTH-1:0] calc_power_mod(
        input logic [BASE_WIDTH-1:0] base,
        input logic [EXP_WIDTH-1:0]  expo,
        input logic [MOD_WIDTH-1:0]  modulus
    );
        logic [63:0]          acc;
        logic [63:0]          pw;
        logic [63:0]          m64;
        logic [EXP_WIDTH-1:0] bits_left;
        if (expo == '0)
            return OUT_WIDTH'(1);
        if (modulus == '0)
            return '0;
        m64       = {{(64-MOD_WIDTH){1'b0}}, modulus};
        acc       = 64'd1;
        pw        = {1'b0, base} % m64;
        bits_left = expo;
        while (bits_left != '0) begin
            if (bits_left[0])
                acc = (acc * pw) % m64;
            pw        = (pw * pw) % m64;
            bits_left = bits_left >> 1;
        end
        return acc[OUT_WIDTH-1:0];
    endfunction

    // Hand one transaction to the block and queue its expected result.
    task automatic send_item(
        input logic [BASE_WIDTH-1:0] base,
        input logic [EXP_WIDTH-1:0]  expo,
        input logic [MOD_WIDTH-1:0]  modulus,
        input bit                    fixed,
        input logic [OUT_WIDTH-1:0]  fixed_val,
        input int                    idle_pct
    );
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_base_value <= base;
        i_exponent   <= expo;
        i_modulus    <= modulus;
        do @(posedge i_clk); while (o_busy);
        want_fifo[want_wr % WANT_DEPTH] = fixed ? fixed_val
                                                : calc_power_mod(base, expo, modulus);
        want_wr++;
    endtask

    // Drop start and hold off until every queued result has come back.
    task automatic drain_results();
        i_start <= 1'b0;
        while (want_wr != want_rd)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (want_wr == want_rd) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: power_mod=%h", o_power_mod);
            end else begin
                want_power_mod = want_fifo[want_rd % WANT_DEPTH];
                want_rd++;
                if (o_power_mod !== want_power_mod) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("power_mod mismatch: expected %h, got %h",
                                 want_power_mod, o_power_mod);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [63:0]           rnd;
        logic [BASE_WIDTH-1:0] r_base;
        logic [EXP_WIDTH-1:0]  r_expo;
        logic [MOD_WIDTH-1:0]  r_mod;
        int                    exp_bits;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_item(directed_vec[i].base, directed_vec[i].expo, directed_vec[i].modulus,
                      directed_vec[i].fixed, directed_vec[i].fixed_val, SEND_IDLE_PCT[0]);
        drain_results();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                rnd = {$urandom, $urandom};
                if ($urandom_range(0, 3) == 0)
                    r_base = BASE_WIDTH'($urandom_range(0, 1000));
                else
                    r_base = rnd[BASE_WIDTH-1:0];

                // Spread exponent lengths so short and long scans both show up.
                rnd      = {$urandom, $urandom};
                exp_bits = $urandom_range(0, EXP_WIDTH);
                if (exp_bits == 0)
                    r_expo = '0;
                else
                    r_expo = rnd[EXP_WIDTH-1:0] >> (EXP_WIDTH - exp_bits);

                case ($urandom_range(0, 9))
                    0: r_mod = MOD_WIDTH'($urandom_range(0, 1));
                    1: r_mod = MOD_WIDTH'($urandom_range(2, 255));
                    2: r_mod = MAX_MOD - MOD_WIDTH'($urandom_range(0, 3));
                    3: r_mod = MOD_WIDTH'(1) << $urandom_range(0, MOD_WIDTH - 1);
                    default: r_mod = $urandom;
                endcase

                send_item(r_base, r_expo, r_mod, 1'b0, '0, SEND_IDLE_PCT[phase]);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[modular_exponentiation.f]
src/mexp_pkg.sv
src/mexp_mulmod.sv
src/modular_exponentiation.sv
verif/tb_modular_exponentiation.sv
